// File: sv/ssan_pkg.sv
// Shared types and constants for the slice sum aggregate normalize block.
`timescale 1ns / 1ps

package ssan_pkg;

   localparam int unsigned PixBits    = 16;
   localparam int unsigned NumInW     = 40;
   localparam int unsigned DenInW     = 24;
   localparam int unsigned NumAccW    = 44;
   localparam int unsigned DenAccW    = 28;
   localparam int unsigned CountW     = 4;
   localparam int unsigned RadiusW    = 3;
   localparam int unsigned CsrDataW   = 28;
   localparam int unsigned CsrIndexW  = 1;
   // dividend is 2*num + den, divisor 2*den
   localparam int unsigned DividendW  = NumAccW + 2;
   localparam int unsigned StepW      = $clog2(PixBits + 1);

   localparam logic [CsrIndexW-1:0] CSR_SLICE_RADIUS  = 1'b0;
   localparam logic [CsrIndexW-1:0] CSR_DEN_THRESHOLD = 1'b1;

   typedef struct packed {
      logic [NumAccW-1:0] num;
      logic [DenAccW-1:0] den;
      logic [PixBits-1:0] src;
      logic               fallback;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BACK_IDLE = 3'b001,
      BACK_DIV  = 3'b010,
      BACK_DONE = 3'b100
   } back_state_type;

endpackage

// File: sv/ssan_front.sv
// Front end: config registers, slice accumulation and pixel close-out.
`timescale 1ns / 1ps

module ssan_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [ssan_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [ssan_pkg::CsrDataW-1:0]     csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ssan_pkg::NumInW-1:0]       req_num_slice,
   input  logic [ssan_pkg::DenInW-1:0]       req_den_slice,
   input  logic [ssan_pkg::PixBits-1:0]      req_source_pixel,
   input  ssan_pkg::queue_status_type        q_status,
   output logic                              q_push,
   output ssan_pkg::job_type                 q_job
);

   logic [ssan_pkg::RadiusW-1:0]  radius_ff, radius_in;
   logic [ssan_pkg::DenAccW-1:0]  thresh_ff, thresh_in;
   logic [ssan_pkg::NumAccW-1:0]  num_acc_ff, num_acc_in;
   logic [ssan_pkg::DenAccW-1:0]  den_acc_ff, den_acc_in;
   logic [ssan_pkg::CountW-1:0]   count_ff, count_in;

   logic [ssan_pkg::NumAccW:0]    num_sum;
   logic [ssan_pkg::DenAccW:0]    den_sum;
   logic [ssan_pkg::NumAccW-1:0]  num_new;
   logic [ssan_pkg::DenAccW-1:0]  den_new;
   logic [ssan_pkg::CountW:0]     count_next;
   logic [ssan_pkg::CountW:0]     slices;
   logic                          last;
   logic                          accept;

   // 3-bit radius cannot exceed the maximum radius of 7, so no clamp
   assign slices     = {1'b0, radius_ff, 1'b1};
   assign count_next = {1'b0, count_ff} + (ssan_pkg::CountW+1)'(1);
   assign last       = !(count_next < slices);

   assign num_sum = {1'b0, num_acc_ff}
                  + {{(ssan_pkg::NumAccW+1-ssan_pkg::NumInW){1'b0}}, req_num_slice};
   assign den_sum = {1'b0, den_acc_ff}
                  + {{(ssan_pkg::DenAccW+1-ssan_pkg::DenInW){1'b0}}, req_den_slice};
   // saturate at accumulator width
   assign num_new = num_sum[ssan_pkg::NumAccW] ? '1 : num_sum[ssan_pkg::NumAccW-1:0];
   assign den_new = den_sum[ssan_pkg::DenAccW] ? '1 : den_sum[ssan_pkg::DenAccW-1:0];

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign q_push    = accept && last;

   always_comb begin
      q_job.num      = num_new;
      q_job.den      = den_new;
      q_job.src      = req_source_pixel;
      q_job.fallback = !(den_new > thresh_ff);
   end

   always_comb begin
      radius_in  = radius_ff;
      thresh_in  = thresh_ff;
      num_acc_in = num_acc_ff;
      den_acc_in = den_acc_ff;
      count_in   = count_ff;
      if (csr_write) begin
         unique case (csr_index)
            ssan_pkg::CSR_SLICE_RADIUS:  radius_in = csr_data[ssan_pkg::RadiusW-1:0];
            ssan_pkg::CSR_DEN_THRESHOLD: thresh_in = csr_data[ssan_pkg::DenAccW-1:0];
            default: ;
         endcase
      end
      if (accept) begin
         if (last) begin
            num_acc_in = '0;
            den_acc_in = '0;
            count_in   = '0;
         end else begin
            num_acc_in = num_new;
            den_acc_in = den_new;
            count_in   = count_next[ssan_pkg::CountW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= '0;
         thresh_ff  <= '0;
         num_acc_ff <= '0;
         den_acc_ff <= '0;
         count_ff   <= '0;
      end else begin
         radius_ff  <= radius_in;
         thresh_ff  <= thresh_in;
         num_acc_ff <= num_acc_in;
         den_acc_ff <= den_acc_in;
         count_ff   <= count_in;
      end
   end

endmodule

// File: sv/ssan_queue.sv
// Two-entry job queue between the accumulator and the divider.
`timescale 1ns / 1ps

module ssan_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ssan_pkg::job_type          push_job,
   input  logic                       pop,
   output ssan_pkg::job_type          pop_job,
   output ssan_pkg::queue_status_type status
);

   ssan_pkg::job_type entry_ff [2];
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   logic [1:0]        count_ff, count_in;

   assign pop_job      = entry_ff[rptr_ff];
   assign status.full  = count_ff == 2'd2;
   assign status.empty = count_ff == 2'd0;

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop  ? !rptr_ff : rptr_ff;
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + 2'd1;
      else if (pop && !push)
         count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: sv/ssan_back.sv
// Back end: restoring divider with rounding and saturation, output register.
`timescale 1ns / 1ps

module ssan_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ssan_pkg::queue_status_type    q_status,
   input  ssan_pkg::job_type             q_job,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ssan_pkg::PixBits-1:0]  rsp_result_pixel,
   output logic                          rsp_fallback_used
);

   ssan_pkg::back_state_type              state_ff, state_in;
   logic [ssan_pkg::DividendW-1:0]        rem_ff, rem_in;
   logic [ssan_pkg::DividendW-1:0]        dvs_ff, dvs_in;
   logic [ssan_pkg::StepW-1:0]            step_ff, step_in;
   logic [ssan_pkg::PixBits-1:0]          quo_ff, quo_in;
   logic                                  fb_ff, fb_in;
   logic                                  out_valid_ff, out_valid_in;
   logic [ssan_pkg::PixBits-1:0]          out_pix_ff, out_pix_in;
   logic                                  out_fb_ff, out_fb_in;

   logic                                  ge;
   logic                                  out_free;

   assign ge       = !(rem_ff < dvs_ff);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == ssan_pkg::BACK_IDLE) && !q_status.empty;

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_pixel  = out_pix_ff;
   assign rsp_fallback_used = out_fb_ff;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      fb_in        = fb_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_pix_in   = out_pix_ff;
      out_fb_in    = out_fb_ff;
      unique case (state_ff)
         ssan_pkg::BACK_IDLE: begin
            if (!q_status.empty) begin
               // rounding: floor((2*num + den) / (2*den))
               rem_in  = {1'b0, q_job.num, 1'b0}
                       + {{(ssan_pkg::DividendW-ssan_pkg::DenAccW){1'b0}}, q_job.den};
               // first compare is against divisor << PixBits: saturation test
               dvs_in  = {1'b0, q_job.den, {(ssan_pkg::PixBits+1){1'b0}}};
               step_in = ssan_pkg::StepW'(ssan_pkg::PixBits);
               quo_in  = '0;
               fb_in   = q_job.fallback;
               if (q_job.fallback) begin
                  quo_in   = q_job.src;
                  state_in = ssan_pkg::BACK_DONE;
               end else begin
                  state_in = ssan_pkg::BACK_DIV;
               end
            end
         end
         ssan_pkg::BACK_DIV: begin
            if (ge)
               rem_in = rem_ff - dvs_ff;
            dvs_in  = dvs_ff >> 1;
            quo_in  = {quo_ff[ssan_pkg::PixBits-2:0], ge};
            step_in = step_ff - ssan_pkg::StepW'(1);
            if (step_ff == ssan_pkg::StepW'(ssan_pkg::PixBits) && ge) begin
               quo_in   = '1;
               state_in = ssan_pkg::BACK_DONE;
            end else if (step_ff == '0) begin
               state_in = ssan_pkg::BACK_DONE;
            end
         end
         ssan_pkg::BACK_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_pix_in   = quo_ff;
               out_fb_in    = fb_ff;
               state_in     = ssan_pkg::BACK_IDLE;
            end
         end
         default: state_in = ssan_pkg::BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      step_ff    <= step_in;
      quo_ff     <= quo_in;
      fb_ff      <= fb_in;
      out_pix_ff <= out_pix_in;
      out_fb_ff  <= out_fb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssan_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: sv/slice_sum_aggregate_normalize.sv
// Top level of the slice sum aggregate normalize block.
`timescale 1ns / 1ps

// Aggregates 2*radius+1 temporal slices per pixel and normalizes the sums.
// req_*: one slice per transaction (numerator, weight sum, source pixel),
//   taken when req_valid is high and req_stall low. The front accumulates
//   one slice per cycle while req_stall is low; the last slice of a pixel
//   closes it into a two-entry job queue.
// rsp_*: one transaction per pixel: the rounded quotient, saturated to
//   16 bits, or the source pixel with rsp_fallback_used set when the
//   weight sum does not exceed den_threshold.
// csr_*: csr_index 0 is slice_radius, 1 is den_threshold; write only
//   while the block is idle.
// Divider: a divided pixel passes through the restoring divider, one
//   quotient bit per cycle plus a saturation test; the divider stops
//   early when the quotient saturates on the first test, and a fallback
//   pixel skips the divider.
// Throughput: one slice per cycle at the input while req_stall is low; the
//   divider sets the pixel rate, taking a new job only once it is idle.
// Reset clears the accumulators and queue, idles the divider and clears rsp_valid.
// When the receiver stalls, the result holds in the output register, the
//   divider finishes its job, and req_stall rises once the queue fills.
module slice_sum_aggregate_normalize (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [ssan_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [ssan_pkg::CsrDataW-1:0]     csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ssan_pkg::NumInW-1:0]       req_num_slice,
   input  logic [ssan_pkg::DenInW-1:0]       req_den_slice,
   input  logic [ssan_pkg::PixBits-1:0]      req_source_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ssan_pkg::PixBits-1:0]      rsp_result_pixel,
   output logic                              rsp_fallback_used
);

   ssan_pkg::queue_status_type q_status;
   ssan_pkg::job_type          push_job;
   ssan_pkg::job_type          pop_job;
   logic                       q_push;
   logic                       q_pop;

   ssan_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_num_slice    (req_num_slice),
      .req_den_slice    (req_den_slice),
      .req_source_pixel (req_source_pixel),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_job            (push_job)
   );

   ssan_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   ssan_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .q_job             (pop_job),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_pixel  (rsp_result_pixel),
      .rsp_fallback_used (rsp_fallback_used)
   );

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("job pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("job popped from empty queue");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule
